### hdl/knn_pkg.sv
package knn_pkg;
    localparam int DIST_W = 32;
    localparam int OP_W   = 2;
    localparam int VTX_W  = 10;
    localparam int RANK_W = 3;
    localparam int CID_W  = 16;
    localparam logic [OP_W-1:0] OP_OFFER = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;
    localparam logic [0:0] CFG_EMPTY = 1'd0;
    localparam logic [0:0] CFG_TOL   = 1'd1;

    // classified request, queued between front and back
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [VTX_W-1:0]  vertex;
        logic [RANK_W-1:0] rank;
        logic [DIST_W-1:0] cand_dist;
        logic [DIST_W-1:0] sum;
        logic [CID_W-1:0]  id;
    } req_t;

    typedef struct packed {
        logic              changed;
        logic [DIST_W-1:0] read_distance;
        logic [CID_W-1:0]  read_id;
        logic              read_valid;
    } res_t;
endpackage

### hdl/knn_front.sv
module knn_front #(
    parameter int VERTEX_COUNT = 1024,
    parameter int LIST_LENGTH  = 8,
    parameter int ID_WIDTH     = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [63:0]         in_data,
    input  logic [15:0]         tolerance,
    output logic                q_valid,
    input  logic                q_ready,
    output knn_pkg::req_t       q_data
);
    import knn_pkg::*;
    localparam int QD = 2;
    req_t        q_reg [QD];
    logic [1:0]  cnt_reg, cnt_next;
    logic        wp_reg, rp_reg;
    req_t        cls;
    logic [DIST_W:0] wide;
    logic        push, pop;

    always_comb begin
        cls.op        = in_data[1:0];
        cls.vertex    = in_data[11:2];
        cls.rank      = in_data[14:12];
        cls.cand_dist = in_data[46:15];
        cls.id        = in_data[62:47] & CID_W'((33'd1 << ID_WIDTH) - 33'd1);
        wide = {1'b0, cls.cand_dist} + (in_data[63] ? {17'd0, tolerance} : '0);
        cls.sum = wide[DIST_W] ? '1 : wide[DIST_W-1:0];
        if (32'(cls.vertex) >= VERTEX_COUNT) cls.op = OP_NOP;
        if (cls.op == OP_READ && 32'(cls.rank) >= LIST_LENGTH) cls.op = OP_NOP;
    end

    assign in_ready = (cnt_reg != 2'(QD));
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_data = q_reg[rp_reg];
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0; wp_reg <= 1'b0; rp_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
        end
        if (push) q_reg[wp_reg] <= cls;
    end
endmodule

### hdl/knn_back.sv
module knn_back #(
    parameter int VERTEX_COUNT = 1024,
    parameter int LIST_LENGTH  = 8,
    parameter int ID_WIDTH     = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  knn_pkg::req_t       q_data,
    input  logic [31:0]         empty_distance,
    output logic                busy,
    output logic                r_valid,
    input  logic                r_ready,
    output knn_pkg::res_t       r_data
);
    import knn_pkg::*;
    localparam int VA = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int RA = (LIST_LENGTH > 1) ? $clog2(LIST_LENGTH) : 1;
    localparam int RW = LIST_LENGTH * (DIST_W + ID_WIDTH + 1);
    localparam logic [1:0] S_IDLE = 2'd0, S_WORK = 2'd1, S_WIPE = 2'd2;

    typedef struct packed {
        logic [DIST_W-1:0]   d;
        logic [ID_WIDTH-1:0] id;
        logic                occ;
    } ent_t;

    // one row per vertex
    logic [RW-1:0] mem [VERTEX_COUNT];
    logic [RW-1:0] rd_reg;
    logic [1:0]    st_reg;
    logic [VA-1:0] wipe_reg;
    req_t          cur_reg;
    logic          rv_reg;
    res_t          res_reg;
    ent_t          row [LIST_LENGTH];
    ent_t          mod [LIST_LENGTH];
    ent_t          srt [LIST_LENGTH];
    ent_t          ecl;
    logic          chg, found, we;
    logic [RW-1:0] wdata;
    logic [VA-1:0] waddr;
    logic [RA-1:0] rk;
    res_t          res_next;

    assign ecl = '{d: empty_distance, id: '0, occ: 1'b0};

    always_comb begin
        for (int k = 0; k < LIST_LENGTH; k++) row[k] = rd_reg[k*$bits(ent_t) +: $bits(ent_t)];
        mod = row; chg = 1'b0; found = 1'b0;
        if (cur_reg.sum <= row[LIST_LENGTH-1].d) begin
            for (int k = 0; k < LIST_LENGTH; k++)
                if (!found && row[k].occ && row[k].id == ID_WIDTH'(cur_reg.id)) begin
                    found = 1'b1;
                    if (cur_reg.sum <= row[k].d) begin
                        mod[k].d = cur_reg.cand_dist; chg = 1'b1;
                    end
                end
            if (!found) begin
                mod[LIST_LENGTH-1] = '{d: cur_reg.cand_dist, id: ID_WIDTH'(cur_reg.id),
                                       occ: 1'b1};
                chg = 1'b1;
            end
        end
        // rank-based stable sort: list was sorted except one element
        srt = mod;
        for (int i = 0; i < LIST_LENGTH; i++) begin
            int p;
            p = 0;
            for (int j = 0; j < LIST_LENGTH; j++)
                if (mod[j].d < mod[i].d || (mod[j].d == mod[i].d && j < i)) p++;
            srt[p[RA-1:0]] = mod[i];
        end
    end

    always_comb begin
        rk = RA'(cur_reg.rank);
        res_next = '0;
        if (cur_reg.op == OP_OFFER) res_next.changed = chg;
        if (cur_reg.op == OP_READ) begin
            res_next.read_distance = row[rk].d;
            if (row[rk].occ) begin
                res_next.read_id = CID_W'(row[rk].id);
                res_next.read_valid = 1'b1;
            end
        end
        we = 1'b0; waddr = VA'(cur_reg.vertex); wdata = '0;
        for (int k = 0; k < LIST_LENGTH; k++) wdata[k*$bits(ent_t) +: $bits(ent_t)] = ecl;
        if (st_reg == S_WIPE) begin
            we = 1'b1; waddr = wipe_reg;
        end else if (st_reg == S_WORK && !rv_reg) begin
            if (cur_reg.op == OP_CLEAR) we = 1'b1;
            else if (cur_reg.op == OP_OFFER && chg) begin
                we = 1'b1;
                for (int k = 0; k < LIST_LENGTH; k++)
                    wdata[k*$bits(ent_t) +: $bits(ent_t)] = srt[k];
            end
        end
    end

    // take the next request in the cycle the waiting result leaves
    assign q_ready = (st_reg == S_IDLE) && (!rv_reg || r_ready);
    assign busy = (st_reg != S_IDLE) || rv_reg || q_valid;
    assign r_valid = rv_reg;
    assign r_data = res_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (q_valid && q_ready) rd_reg <= mem[VA'(q_data.vertex)];
        if (q_valid && q_ready) cur_reg <= q_data;
        if (st_reg == S_WORK) res_reg <= res_next;
        if (!aresetn) begin
            st_reg <= S_WIPE; wipe_reg <= '0; rv_reg <= 1'b0;
        end else begin
            case (st_reg)
                S_WIPE: begin
                    wipe_reg <= wipe_reg + 1'b1;
                    if (32'(wipe_reg) == VERTEX_COUNT - 1) st_reg <= S_IDLE;
                end
                S_IDLE: if (q_valid && q_ready) st_reg <= S_WORK;
                S_WORK: begin rv_reg <= 1'b1; st_reg <= S_IDLE; end
                default: st_reg <= S_IDLE;
            endcase
            if (rv_reg && r_ready) rv_reg <= 1'b0;
        end
    end
endmodule

### hdl/knn_distance_list_update.sv
// A request passes the queue, the row read and the update before its result is registered.
// The back end takes no new request until the last one is done and its result is accepted,
// as set by the row read then write-back of the list memory. Reset (synchronous, aresetn low)
// clears the queue and registers, then a clearing pass over every vertex fills every list with
// 0xFFFFFFFF; up to two requests wait in the queue meanwhile and none is carried out.
module knn_distance_list_update #(
    parameter int LIST_LENGTH  = 8,
    parameter int VERTEX_COUNT = 1024,
    parameter int ID_WIDTH     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[1:0] vertex[11:2] rank[14:12] candidate_distance[46:15]
    // candidate_id[62:47] use_tolerance[63]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // changed[0] read_distance[32:1] read_id[48:33] read_valid[49], zero fill
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import knn_pkg::*;
    logic [31:0] empty_reg;
    logic [15:0] tol_reg;
    logic        q_valid, q_ready, busy;
    req_t        q_data;
    res_t        r_data;

    // hold configuration off while any request is in flight
    assign cfg_ready = !busy;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_reg <= '1; tol_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_EMPTY: empty_reg <= cfg_data;
                CFG_TOL:   tol_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // front: classify and queue requests
    knn_front #(.VERTEX_COUNT(VERTEX_COUNT), .LIST_LENGTH(LIST_LENGTH),
                .ID_WIDTH(ID_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .tolerance(tol_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data));

    // back: read the row, update, sort, write back
    knn_back #(.VERTEX_COUNT(VERTEX_COUNT), .LIST_LENGTH(LIST_LENGTH),
               .ID_WIDTH(ID_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .empty_distance(empty_reg), .busy(busy),
        .r_valid(m_tvalid), .r_ready(m_tready), .r_data(r_data));

    // pack the result with the first field in the lowest bit
    assign m_tdata = {6'd0, r_data.read_valid, r_data.read_id, r_data.read_distance,
                      r_data.changed};
endmodule
